[rtl/sgr_attribute_decoder_assert.svh]
// Assertion macros for the SGR attribute decoder.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef SGR_ATTRIBUTE_DECODER_ASSERT_SVH
`define SGR_ATTRIBUTE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sgr_attr_pkg.sv]
package sgr_attr_pkg;

  // Field widths
  localparam int VALUE_W = 16;
  localparam int AFTER_W = 5;
  localparam int FLAG_W  = 9;
  localparam int KIND_W  = 2;
  localparam int COL_W   = 24;

  localparam int MAX_PARAMS_DEF = 32;

  // Style flag bit positions
  localparam int FLAG_BOLD      = 0;
  localparam int FLAG_FAINT     = 1;
  localparam int FLAG_ITALIC    = 2;
  localparam int FLAG_UNDERLINE = 3;
  localparam int FLAG_BLINK     = 4;
  localparam int FLAG_INVERSE   = 5;
  localparam int FLAG_HIDDEN    = 6;
  localparam int FLAG_STRIKE    = 7;
  localparam int FLAG_DUNDER    = 8;

  // Color kinds
  localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INDEXED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RGB     = 2'd2;

  // Color targets of an extended form
  localparam logic [1:0] TGT_FORE  = 2'd0;
  localparam logic [1:0] TGT_BACK  = 2'd1;
  localparam logic [1:0] TGT_UNDER = 2'd2;

  // SGR codes
  localparam logic [VALUE_W-1:0] SGR_RESET      = 16'd0;
  localparam logic [VALUE_W-1:0] SGR_BOLD       = 16'd1;
  localparam logic [VALUE_W-1:0] SGR_FAINT      = 16'd2;
  localparam logic [VALUE_W-1:0] SGR_ITALIC     = 16'd3;
  localparam logic [VALUE_W-1:0] SGR_UNDERLINE  = 16'd4;
  localparam logic [VALUE_W-1:0] SGR_BLINK_SLOW = 16'd5;
  localparam logic [VALUE_W-1:0] SGR_BLINK_FAST = 16'd6;
  localparam logic [VALUE_W-1:0] SGR_INVERSE    = 16'd7;
  localparam logic [VALUE_W-1:0] SGR_HIDDEN     = 16'd8;
  localparam logic [VALUE_W-1:0] SGR_STRIKE     = 16'd9;
  localparam logic [VALUE_W-1:0] SGR_DUNDER     = 16'd21;
  localparam logic [VALUE_W-1:0] SGR_NORMAL_INT = 16'd22;
  localparam logic [VALUE_W-1:0] SGR_NO_ITALIC  = 16'd23;
  localparam logic [VALUE_W-1:0] SGR_NO_UNDER   = 16'd24;
  localparam logic [VALUE_W-1:0] SGR_NO_BLINK   = 16'd25;
  localparam logic [VALUE_W-1:0] SGR_NO_INVERSE = 16'd27;
  localparam logic [VALUE_W-1:0] SGR_NO_HIDDEN  = 16'd28;
  localparam logic [VALUE_W-1:0] SGR_NO_STRIKE  = 16'd29;
  localparam logic [VALUE_W-1:0] SGR_FG_EXT     = 16'd38;
  localparam logic [VALUE_W-1:0] SGR_FG_DEFAULT = 16'd39;
  localparam logic [VALUE_W-1:0] SGR_BG_EXT     = 16'd48;
  localparam logic [VALUE_W-1:0] SGR_BG_DEFAULT = 16'd49;
  localparam logic [VALUE_W-1:0] SGR_UL_EXT     = 16'd58;
  localparam logic [VALUE_W-1:0] SGR_UL_DEFAULT = 16'd59;

  // Basic color ranges
  localparam logic [VALUE_W-1:0] SGR_FG_FIRST    = 16'd30;
  localparam logic [VALUE_W-1:0] SGR_FG_LAST     = 16'd37;
  localparam logic [VALUE_W-1:0] SGR_BG_FIRST    = 16'd40;
  localparam logic [VALUE_W-1:0] SGR_BG_LAST     = 16'd47;
  localparam logic [VALUE_W-1:0] SGR_FG_HI_FIRST = 16'd90;
  localparam logic [VALUE_W-1:0] SGR_FG_HI_LAST  = 16'd97;
  localparam logic [VALUE_W-1:0] SGR_BG_HI_FIRST = 16'd100;
  localparam logic [VALUE_W-1:0] SGR_BG_HI_LAST  = 16'd107;

  // Extended form selectors and the parameters each needs after the code
  localparam logic [VALUE_W-1:0] SEL_INDEXED = 16'd5;
  localparam logic [VALUE_W-1:0] SEL_RGB     = 16'd2;
  localparam logic [AFTER_W-1:0] NEED_INDEXED = 5'd2;
  localparam logic [AFTER_W-1:0] NEED_RGB     = 5'd4;

  localparam logic [VALUE_W-1:0] BYTE_MAX = 16'd255;

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_SELECT,
    PH_INDEX,
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  value;
  } colour_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    colour_t           fore;
    colour_t           back;
    colour_t           under;
  } result_t;

endpackage

[rtl/sgr_attr_if.sv]
// Parameter channel: one SGR parameter per item
interface sgr_attr_in_if;
  logic                               valid;
  logic                               ready;
  logic [sgr_attr_pkg::VALUE_W-1:0]   param_value;
  logic                               param_present;
  logic [sgr_attr_pkg::AFTER_W-1:0]   params_after;

  modport source (output valid, param_value, param_present, params_after, input ready);
  modport sink   (input valid, param_value, param_present, params_after, output ready);
endinterface

// Attribute channel: current attributes after each item
interface sgr_attr_out_if;
  logic                               valid;
  logic                               ready;
  logic [sgr_attr_pkg::FLAG_W-1:0]    style_flags;
  logic [sgr_attr_pkg::KIND_W-1:0]    fore_kind;
  logic [sgr_attr_pkg::COL_W-1:0]     fore_value;
  logic [sgr_attr_pkg::KIND_W-1:0]    back_kind;
  logic [sgr_attr_pkg::COL_W-1:0]     back_value;
  logic [sgr_attr_pkg::KIND_W-1:0]    under_kind;
  logic [sgr_attr_pkg::COL_W-1:0]     under_value;

  modport source (output valid, style_flags, fore_kind, fore_value, back_kind, back_value,
                  under_kind, under_value, input ready);
  modport sink   (input valid, style_flags, fore_kind, fore_value, back_kind, back_value,
                  under_kind, under_value, output ready);
endinterface

[rtl/sgr_attribute_decoder.sv]
// SGR attribute decoder.
// in_chan carries the parameters of SGR sequences, one item each, with the
// count of parameters still following in the same sequence. An empty
// sequence arrives as one item with param_present low and params_after 0.
// out_chan answers every item with one item: the style flags and the
// foreground, background and underline colors as they stand after it.
// Results land in the output register or, while it stalls, the skid entry.
// Throughput: one item per cycle while in_chan.ready is high; each item
// is decoded by one case decode against the attribute and extended-form
// registers, which are updated at the accepting edge.
// Stall: an output register plus one skid entry hold results; in_chan.ready
// drops only while the skid entry is occupied, so at most two results wait.
// Reset (rst_n low at a clock edge): attributes return to default, any
// pending extended color form is dropped, and both result slots empty.
// MAX_PARAMS saturates params_after at MAX_PARAMS - 1, or at 31 if smaller.
`include "sgr_attribute_decoder_assert.svh"

module sgr_attribute_decoder #(
  parameter int MAX_PARAMS = sgr_attr_pkg::MAX_PARAMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  sgr_attr_in_if.sink     in_chan,
  sgr_attr_out_if.source  out_chan
);

  localparam int AW = sgr_attr_pkg::AFTER_W;
  localparam int AFTER_CAP_I = (MAX_PARAMS - 1 > (1 << AW) - 1) ? (1 << AW) - 1
                                                                : MAX_PARAMS - 1;
  localparam logic [AW-1:0] AFTER_CAP = AW'(AFTER_CAP_I);

  // Attribute and extended-form state
  logic [sgr_attr_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  sgr_attr_pkg::colour_t           fore_r, fore_nxt;
  sgr_attr_pkg::colour_t           back_r, back_nxt;
  sgr_attr_pkg::colour_t           under_r, under_nxt;
  sgr_attr_pkg::phase_t            phase_r, phase_nxt;
  logic [1:0]                      target_r, target_nxt;
  logic [AW-1:0]                   remaining_r, remaining_nxt;
  logic [7:0]                      red_r, red_nxt;
  logic [7:0]                      green_r, green_nxt;

  // Result slots
  sgr_attr_pkg::result_t out_r, skid_r, result_nxt;
  logic                  out_valid_r, skid_valid_r;

  logic                              accept, pop;
  logic [sgr_attr_pkg::VALUE_W-1:0]  value;
  logic [sgr_attr_pkg::VALUE_W-1:0]  offset;
  logic [7:0]                        clamped;
  logic [AW-1:0]                     after_sat;
  logic                              set_col;
  sgr_attr_pkg::colour_t             new_colour;

  assign accept       = in_chan.valid && in_chan.ready;
  assign pop          = out_valid_r && out_chan.ready;
  assign in_chan.ready = !skid_valid_r;

  // Decode of one parameter
  always_comb begin
    flags_nxt     = flags_r;
    fore_nxt      = fore_r;
    back_nxt      = back_r;
    under_nxt     = under_r;
    phase_nxt     = sgr_attr_pkg::PH_NORMAL;
    target_nxt    = target_r;
    remaining_nxt = remaining_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    set_col       = 1'b0;
    new_colour    = '0;
    offset        = '0;

    value     = in_chan.param_present ? in_chan.param_value : '0;
    clamped   = (value > sgr_attr_pkg::BYTE_MAX) ? 8'hFF : value[7:0];
    after_sat = (in_chan.params_after > AFTER_CAP) ? AFTER_CAP : in_chan.params_after;

    unique case (phase_r)
      sgr_attr_pkg::PH_SELECT: begin
        if (in_chan.param_present && value == sgr_attr_pkg::SEL_INDEXED &&
            remaining_r >= sgr_attr_pkg::NEED_INDEXED) begin
          phase_nxt = sgr_attr_pkg::PH_INDEX;
        end else if (in_chan.param_present && value == sgr_attr_pkg::SEL_RGB &&
                     remaining_r >= sgr_attr_pkg::NEED_RGB) begin
          phase_nxt = sgr_attr_pkg::PH_RED;
        end
      end
      sgr_attr_pkg::PH_INDEX: begin
        set_col    = 1'b1;
        new_colour = '{kind: sgr_attr_pkg::KIND_INDEXED, value: {16'd0, clamped}};
      end
      sgr_attr_pkg::PH_RED: begin
        red_nxt   = clamped;
        phase_nxt = sgr_attr_pkg::PH_GREEN;
      end
      sgr_attr_pkg::PH_GREEN: begin
        green_nxt = clamped;
        phase_nxt = sgr_attr_pkg::PH_BLUE;
      end
      sgr_attr_pkg::PH_BLUE: begin
        set_col    = 1'b1;
        new_colour = '{kind: sgr_attr_pkg::KIND_RGB, value: {red_r, green_r, clamped}};
      end
      default: begin
        // Ordinary code
        unique case (value)
          sgr_attr_pkg::SGR_RESET: begin
            flags_nxt = '0;
            fore_nxt  = '0;
            back_nxt  = '0;
            under_nxt = '0;
          end
          sgr_attr_pkg::SGR_BOLD:       flags_nxt[sgr_attr_pkg::FLAG_BOLD]      = 1'b1;
          sgr_attr_pkg::SGR_FAINT:      flags_nxt[sgr_attr_pkg::FLAG_FAINT]     = 1'b1;
          sgr_attr_pkg::SGR_ITALIC:     flags_nxt[sgr_attr_pkg::FLAG_ITALIC]    = 1'b1;
          sgr_attr_pkg::SGR_UNDERLINE:  flags_nxt[sgr_attr_pkg::FLAG_UNDERLINE] = 1'b1;
          sgr_attr_pkg::SGR_BLINK_SLOW,
          sgr_attr_pkg::SGR_BLINK_FAST: flags_nxt[sgr_attr_pkg::FLAG_BLINK]     = 1'b1;
          sgr_attr_pkg::SGR_INVERSE:    flags_nxt[sgr_attr_pkg::FLAG_INVERSE]   = 1'b1;
          sgr_attr_pkg::SGR_HIDDEN:     flags_nxt[sgr_attr_pkg::FLAG_HIDDEN]    = 1'b1;
          sgr_attr_pkg::SGR_STRIKE:     flags_nxt[sgr_attr_pkg::FLAG_STRIKE]    = 1'b1;
          sgr_attr_pkg::SGR_DUNDER:     flags_nxt[sgr_attr_pkg::FLAG_DUNDER]    = 1'b1;
          sgr_attr_pkg::SGR_NORMAL_INT: begin
            flags_nxt[sgr_attr_pkg::FLAG_BOLD]  = 1'b0;
            flags_nxt[sgr_attr_pkg::FLAG_FAINT] = 1'b0;
          end
          sgr_attr_pkg::SGR_NO_ITALIC:  flags_nxt[sgr_attr_pkg::FLAG_ITALIC]    = 1'b0;
          sgr_attr_pkg::SGR_NO_UNDER: begin
            flags_nxt[sgr_attr_pkg::FLAG_UNDERLINE] = 1'b0;
            flags_nxt[sgr_attr_pkg::FLAG_DUNDER]    = 1'b0;
          end
          sgr_attr_pkg::SGR_NO_BLINK:   flags_nxt[sgr_attr_pkg::FLAG_BLINK]     = 1'b0;
          sgr_attr_pkg::SGR_NO_INVERSE: flags_nxt[sgr_attr_pkg::FLAG_INVERSE]   = 1'b0;
          sgr_attr_pkg::SGR_NO_HIDDEN:  flags_nxt[sgr_attr_pkg::FLAG_HIDDEN]    = 1'b0;
          sgr_attr_pkg::SGR_NO_STRIKE:  flags_nxt[sgr_attr_pkg::FLAG_STRIKE]    = 1'b0;
          sgr_attr_pkg::SGR_FG_DEFAULT: fore_nxt  = '0;
          sgr_attr_pkg::SGR_BG_DEFAULT: back_nxt  = '0;
          sgr_attr_pkg::SGR_UL_DEFAULT: under_nxt = '0;
          sgr_attr_pkg::SGR_FG_EXT,
          sgr_attr_pkg::SGR_BG_EXT,
          sgr_attr_pkg::SGR_UL_EXT: begin
            target_nxt    = (value == sgr_attr_pkg::SGR_FG_EXT) ? sgr_attr_pkg::TGT_FORE :
                            (value == sgr_attr_pkg::SGR_BG_EXT) ? sgr_attr_pkg::TGT_BACK :
                                                                  sgr_attr_pkg::TGT_UNDER;
            remaining_nxt = after_sat;
            phase_nxt     = sgr_attr_pkg::PH_SELECT;
          end
          default: begin
            // Basic and bright color ranges; everything else is ignored
            if (value >= sgr_attr_pkg::SGR_FG_FIRST && value <= sgr_attr_pkg::SGR_FG_LAST) begin
              offset   = value - sgr_attr_pkg::SGR_FG_FIRST;
              fore_nxt = '{kind: sgr_attr_pkg::KIND_INDEXED, value: {21'd0, offset[2:0]}};
            end else if (value >= sgr_attr_pkg::SGR_BG_FIRST &&
                         value <= sgr_attr_pkg::SGR_BG_LAST) begin
              offset   = value - sgr_attr_pkg::SGR_BG_FIRST;
              back_nxt = '{kind: sgr_attr_pkg::KIND_INDEXED, value: {21'd0, offset[2:0]}};
            end else if (value >= sgr_attr_pkg::SGR_FG_HI_FIRST &&
                         value <= sgr_attr_pkg::SGR_FG_HI_LAST) begin
              offset   = value - sgr_attr_pkg::SGR_FG_HI_FIRST;
              fore_nxt = '{kind: sgr_attr_pkg::KIND_INDEXED,
                           value: {20'd0, 1'b1, offset[2:0]}};
            end else if (value >= sgr_attr_pkg::SGR_BG_HI_FIRST &&
                         value <= sgr_attr_pkg::SGR_BG_HI_LAST) begin
              offset   = value - sgr_attr_pkg::SGR_BG_HI_FIRST;
              back_nxt = '{kind: sgr_attr_pkg::KIND_INDEXED,
                           value: {20'd0, 1'b1, offset[2:0]}};
            end
          end
        endcase
      end
    endcase

    // Finished extended form lands in its target
    if (set_col) begin
      priority if (target_r == sgr_attr_pkg::TGT_FORE) begin
        fore_nxt = new_colour;
      end else if (target_r == sgr_attr_pkg::TGT_BACK) begin
        back_nxt = new_colour;
      end else begin
        under_nxt = new_colour;
      end
    end

    // Last parameter of a sequence closes any pending form
    if (after_sat == '0) begin
      phase_nxt = sgr_attr_pkg::PH_NORMAL;
    end

    result_nxt = '{flags: flags_nxt, fore: fore_nxt, back: back_nxt, under: under_nxt};
  end

  // Attribute state, updated per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      fore_r      <= '0;
      back_r      <= '0;
      under_r     <= '0;
      phase_r     <= sgr_attr_pkg::PH_NORMAL;
      target_r    <= '0;
      remaining_r <= '0;
      red_r       <= '0;
      green_r     <= '0;
    end else if (accept) begin
      flags_r     <= flags_nxt;
      fore_r      <= fore_nxt;
      back_r      <= back_nxt;
      under_r     <= under_nxt;
      phase_r     <= phase_nxt;
      target_r    <= target_nxt;
      remaining_r <= remaining_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
    end
  end

  // Result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= skid_valid_r ? skid_r : result_nxt;
    end else if (accept) begin
      skid_r <= result_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.style_flags = out_r.flags;
  assign out_chan.fore_kind   = out_r.fore.kind;
  assign out_chan.fore_value  = out_r.fore.value;
  assign out_chan.back_kind   = out_r.back.kind;
  assign out_chan.back_value  = out_r.back.value;
  assign out_chan.under_kind  = out_r.under.kind;
  assign out_chan.under_value = out_r.under.value;

  // Checks
  `SGR_ASSERT_NEXT(a_seq_end_normal, accept && in_chan.params_after == '0,
                   phase_r == sgr_attr_pkg::PH_NORMAL, "extended form survived sequence end")
  `SGR_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_r, "accepted item left no result")
  `SGR_ASSERT_NOW(a_rgb_needs_room,
                  phase_r == sgr_attr_pkg::PH_RED || phase_r == sgr_attr_pkg::PH_GREEN ||
                  phase_r == sgr_attr_pkg::PH_BLUE,
                  remaining_r >= sgr_attr_pkg::NEED_RGB, "rgb form without enough parameters")
  `SGR_ASSERT_NOW(a_default_zero, fore_r.kind == sgr_attr_pkg::KIND_DEFAULT,
                  fore_r.value == '0, "default foreground with nonzero value")

endmodule

[tb/sv/sgr_attr_checker.sv]
// Watches both channels of the SGR attribute decoder, keeps its own copy of
// the attribute state and checks every result item against it, in order.
module sgr_attr_checker
  import sgr_attr_pkg::*;
#(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sgr_attr_in_if      in_mon,
  sgr_attr_out_if     out_mon,
  output int unsigned errors,
  output int unsigned waiting
);

  timeunit 1ns;
  timeprecision 1ps;

  // Predicted attribute state
  logic [FLAG_W-1:0]  cur_flags;
  colour_t            cur_fore;
  colour_t            cur_back;
  colour_t            cur_under;

  // Extended color form in progress
  phase_t             ext_phase;
  logic [1:0]         ext_target;
  logic [AFTER_W-1:0] ext_room;
  logic [7:0]         red_byte;
  logic [7:0]         green_byte;

  // Attributes still owed by the block, oldest first
  result_t            expected_attrs[$];

  initial begin
    errors  = 0;
    waiting = 0;
  end

  function automatic logic [7:0] clamp_level(logic [VALUE_W-1:0] v);
    return (v > BYTE_MAX) ? BYTE_MAX[7:0] : v[7:0];
  endfunction

  function automatic void clear_attrs();
    cur_flags = '0;
    cur_fore  = '0;
    cur_back  = '0;
    cur_under = '0;
  endfunction

  function automatic void store_colour(colour_t c);
    case (ext_target)
      TGT_FORE: cur_fore = c;
      TGT_BACK: cur_back = c;
      default:  cur_under = c;
    endcase
  endfunction

  // Plain SGR code in normal phase
  function automatic void decode_code(logic [VALUE_W-1:0] code, logic [AFTER_W-1:0] after);
    case (code)
      SGR_RESET:      clear_attrs();
      SGR_BOLD:       cur_flags[FLAG_BOLD] = 1'b1;
      SGR_FAINT:      cur_flags[FLAG_FAINT] = 1'b1;
      SGR_ITALIC:     cur_flags[FLAG_ITALIC] = 1'b1;
      SGR_UNDERLINE:  cur_flags[FLAG_UNDERLINE] = 1'b1;
      SGR_BLINK_SLOW,
      SGR_BLINK_FAST: cur_flags[FLAG_BLINK] = 1'b1;
      SGR_INVERSE:    cur_flags[FLAG_INVERSE] = 1'b1;
      SGR_HIDDEN:     cur_flags[FLAG_HIDDEN] = 1'b1;
      SGR_STRIKE:     cur_flags[FLAG_STRIKE] = 1'b1;
      SGR_DUNDER:     cur_flags[FLAG_DUNDER] = 1'b1;
      SGR_NORMAL_INT: begin
        cur_flags[FLAG_BOLD]  = 1'b0;
        cur_flags[FLAG_FAINT] = 1'b0;
      end
      SGR_NO_ITALIC:  cur_flags[FLAG_ITALIC] = 1'b0;
      SGR_NO_UNDER: begin
        cur_flags[FLAG_UNDERLINE] = 1'b0;
        cur_flags[FLAG_DUNDER]    = 1'b0;
      end
      SGR_NO_BLINK:   cur_flags[FLAG_BLINK] = 1'b0;
      SGR_NO_INVERSE: cur_flags[FLAG_INVERSE] = 1'b0;
      SGR_NO_HIDDEN:  cur_flags[FLAG_HIDDEN] = 1'b0;
      SGR_NO_STRIKE:  cur_flags[FLAG_STRIKE] = 1'b0;
      SGR_FG_DEFAULT: cur_fore = '0;
      SGR_BG_DEFAULT: cur_back = '0;
      SGR_UL_DEFAULT: cur_under = '0;
      SGR_FG_EXT, SGR_BG_EXT, SGR_UL_EXT: begin
        ext_target = (code == SGR_FG_EXT) ? TGT_FORE :
                     (code == SGR_BG_EXT) ? TGT_BACK : TGT_UNDER;
        ext_room   = after;
        ext_phase  = PH_SELECT;
      end
      default: begin
        // 16-color ranges; anything else is ignored
        if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST)
          cur_fore = {KIND_INDEXED, COL_W'(code - SGR_FG_FIRST)};
        else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST)
          cur_back = {KIND_INDEXED, COL_W'(code - SGR_BG_FIRST)};
        else if (code >= SGR_FG_HI_FIRST && code <= SGR_FG_HI_LAST)
          cur_fore = {KIND_INDEXED, COL_W'(code - SGR_FG_HI_FIRST + 16'd8)};
        else if (code >= SGR_BG_HI_FIRST && code <= SGR_BG_HI_LAST)
          cur_back = {KIND_INDEXED, COL_W'(code - SGR_BG_HI_FIRST + 16'd8)};
      end
    endcase
  endfunction

  // One parameter item in, the attributes after it out
  function automatic result_t apply_param(logic [VALUE_W-1:0] raw, logic present,
                                          logic [AFTER_W-1:0] raw_after);
    logic [VALUE_W-1:0] v;
    logic [AFTER_W-1:0] after;
    v     = present ? raw : '0;
    after = (int'(raw_after) > MAX_PARAMS - 1) ? AFTER_W'(MAX_PARAMS - 1) : raw_after;

    case (ext_phase)
      PH_SELECT: begin
        // short or malformed forms skip just the selector
        if (present && v == SEL_INDEXED && ext_room >= NEED_INDEXED)
          ext_phase = PH_INDEX;
        else if (present && v == SEL_RGB && ext_room >= NEED_RGB)
          ext_phase = PH_RED;
        else
          ext_phase = PH_NORMAL;
      end
      PH_INDEX: begin
        store_colour({KIND_INDEXED, 16'd0, clamp_level(v)});
        ext_phase = PH_NORMAL;
      end
      PH_RED: begin
        red_byte  = clamp_level(v);
        ext_phase = PH_GREEN;
      end
      PH_GREEN: begin
        green_byte = clamp_level(v);
        ext_phase  = PH_BLUE;
      end
      PH_BLUE: begin
        store_colour({KIND_RGB, red_byte, green_byte, clamp_level(v)});
        ext_phase = PH_NORMAL;
      end
      default: begin
        ext_phase = PH_NORMAL;
        decode_code(v, after);
      end
    endcase

    // end of sequence never leaves a form pending
    if (after == '0)
      ext_phase = PH_NORMAL;

    return {cur_flags, cur_fore, cur_back, cur_under};
  endfunction

  function automatic void check_field(string field, logic [COL_W-1:0] want,
                                      logic [COL_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Predict on accepted parameters, compare on accepted results
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      clear_attrs();
      ext_phase  = PH_NORMAL;
      ext_target = TGT_FORE;
      ext_room   = '0;
      red_byte   = '0;
      green_byte = '0;
      expected_attrs.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_attrs.insert(expected_attrs.size(),
                              apply_param(in_mon.param_value, in_mon.param_present,
                                          in_mon.params_after));
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.style_flags, out_mon.fore_kind, out_mon.fore_value,
               out_mon.back_kind, out_mon.back_value,
               out_mon.under_kind, out_mon.under_value};
        if (expected_attrs.size() == 0) begin
          errors++;
          $display("%0t ns: attribute item with none expected, expected none, actual %0h",
                   $time, got);
        end else begin
          want = expected_attrs.pop_front();
          check_field("style_flags", COL_W'(want.flags), COL_W'(got.flags));
          check_field("fore_kind", COL_W'(want.fore.kind), COL_W'(got.fore.kind));
          check_field("fore_value", want.fore.value, got.fore.value);
          check_field("back_kind", COL_W'(want.back.kind), COL_W'(got.back.kind));
          check_field("back_value", want.back.value, got.back.value);
          check_field("under_kind", COL_W'(want.under.kind), COL_W'(got.under.kind));
          check_field("under_value", want.under.value, got.under.value);
        end
      end
    end
    waiting <= expected_attrs.size();
  end

endmodule

[tb/sv/testbench.sv]
// Drives SGR parameter sequences into the decoder with random gaps and
// output stalls; the checker beside the block predicts and compares.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import sgr_attr_pkg::*;

  localparam int MAX_PARAMS   = MAX_PARAMS_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 357;
  localparam int RANDOM_PHASES = 4;

  logic clk = 1'b0;
  logic rst_n;

  sgr_attr_in_if  in_chan();
  sgr_attr_out_if out_chan();

  int unsigned errors;
  int unsigned waiting;
  int unsigned sent_items;
  int unsigned idle_cycles;
  bit          no_idle;
  bit          hold_off_req;

  // Sequence under construction
  logic [VALUE_W-1:0] seq_vals[$];
  logic               seq_pres[$];

  sgr_attribute_decoder #(.MAX_PARAMS(MAX_PARAMS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sgr_attr_checker #(.MAX_PARAMS(MAX_PARAMS)) i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .errors  (errors),
    .waiting (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall per item, one long hold-off on request
  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  task automatic send_param(input logic [VALUE_W-1:0] v, input logic present,
                            input logic [AFTER_W-1:0] after);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.param_value   <= v;
    in_chan.param_present <= present;
    in_chan.params_after  <= after;
    do @(posedge clk); while (!in_chan.ready);
    sent_items++;
  endtask

  // Sends the built sequence; honest counts give each item its true remainder
  task automatic send_sequence(input bit honest);
    int n;
    n = seq_vals.size();
    for (int i = 0; i < n; i++)
      send_param(seq_vals[i], seq_pres[i],
                 honest ? AFTER_W'(n - 1 - i) : AFTER_W'($urandom_range(0, 31)));
    seq_vals.delete();
    seq_pres.delete();
  endtask

  function automatic void push_param(logic [VALUE_W-1:0] v, logic present);
    seq_vals.insert(seq_vals.size(), v);
    seq_pres.insert(seq_pres.size(), present);
  endfunction

  function automatic logic [VALUE_W-1:0] colour_level();
    case ($urandom_range(0, 9))
      0:       return BYTE_MAX;
      1:       return VALUE_W'($urandom_range(256, 65535));
      default: return VALUE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] ext_code();
    case ($urandom_range(0, 2))
      0:       return SGR_FG_EXT;
      1:       return SGR_BG_EXT;
      default: return SGR_UL_EXT;
    endcase
  endfunction

  // Color value, now and then left empty
  function automatic void push_level();
    push_param(colour_level(), $urandom_range(0, 15) != 0);
  endfunction

  function automatic void push_code();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = VALUE_W'($urandom);
      1:       v = SGR_RESET;
      default: v = VALUE_W'($urandom_range(0, 107));
    endcase
    push_param(v, $urandom_range(0, 15) != 0);
  endfunction

  function automatic void push_ext_form();
    push_param(ext_code(), 1'b1);
    if ($urandom_range(0, 1)) begin
      push_param(SEL_RGB, 1'b1);
      repeat (3) push_level();
    end else begin
      push_param(SEL_INDEXED, 1'b1);
      push_level();
    end
  endfunction

  // Extended form that must be skipped: empty or wrong selector, or truncated
  function automatic void push_broken_form(output bit truncated);
    truncated = 1'b0;
    push_param(ext_code(), 1'b1);
    case ($urandom_range(0, 3))
      0: push_param(VALUE_W'($urandom), 1'b0);
      1: push_param(VALUE_W'($urandom), 1'b1);
      2: begin
        push_param(SEL_INDEXED, 1'b1);
        truncated = 1'b1;
      end
      default: begin
        push_param(SEL_RGB, 1'b1);
        repeat ($urandom_range(0, 2)) push_level();
        truncated = 1'b1;
      end
    endcase
  endfunction

  task automatic random_sequence();
    int unsigned pick;
    bit truncated;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // empty sequence
      push_param(VALUE_W'($urandom), 1'b0);
      send_sequence(1'b1);
    end else if (pick == 1) begin
      // longest sequence the count field allows
      repeat (32) push_code();
      send_sequence(1'b1);
    end else if (pick <= 3) begin
      // noise: arbitrary content and counts
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1)) push_code();
        else push_ext_form();
      end
      send_sequence(1'b0);
    end else if (pick <= 6) begin
      repeat ($urandom_range(0, 2)) push_code();
      push_broken_form(truncated);
      if (!truncated)
        repeat ($urandom_range(0, 3)) push_code();
      send_sequence(1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1)) push_code();
        else push_ext_form();
      end
      send_sequence(1'b1);
    end
  endtask

  // Stop offering until every result is back
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  initial begin
    sent_items    = 0;
    no_idle       = 1'b0;
    hold_off_req  = 1'b0;
    rst_n         <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.param_value   <= '0;
    in_chan.param_present <= 1'b0;
    in_chan.params_after  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty sequence resets everything
    push_param(VALUE_W'($urandom), 1'b0);
    send_sequence(1'b1);
    // every style flag set
    push_param(SGR_BOLD, 1'b1);
    push_param(SGR_FAINT, 1'b1);
    push_param(SGR_ITALIC, 1'b1);
    push_param(SGR_UNDERLINE, 1'b1);
    push_param(SGR_BLINK_FAST, 1'b1);
    push_param(SGR_INVERSE, 1'b1);
    push_param(SGR_HIDDEN, 1'b1);
    push_param(SGR_STRIKE, 1'b1);
    push_param(SGR_DUNDER, 1'b1);
    send_sequence(1'b1);
    // indexed foreground, index clamped
    push_param(SGR_FG_EXT, 1'b1);
    push_param(SEL_INDEXED, 1'b1);
    push_param('1, 1'b1);
    send_sequence(1'b1);
    // rgb background with clamped red and empty green
    push_param(SGR_BG_EXT, 1'b1);
    push_param(SEL_RGB, 1'b1);
    push_param(16'd300, 1'b1);
    push_param('1, 1'b0);
    push_param(BYTE_MAX, 1'b1);
    send_sequence(1'b1);
    // empty selector skipped, next one decoded as a code
    push_param(SGR_UL_EXT, 1'b1);
    push_param(SEL_INDEXED, 1'b0);
    push_param(SGR_BOLD, 1'b1);
    send_sequence(1'b1);
    // extended code last in its sequence
    push_param(SGR_UL_EXT, 1'b1);
    send_sequence(1'b1);
    // unknown code at the top of the range
    push_param('1, 1'b1);
    send_sequence(1'b1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_idle = (p == 1);
      if (p == 2)
        hold_off_req = 1'b1;
      while (sent_items < 23 + (p + 1) * PHASE_ITEMS)
        random_sequence();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && waiting == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/sgr_attr_pkg.sv
rtl/sgr_attr_if.sv
rtl/sgr_attribute_decoder.sv
tb/sv/sgr_attr_checker.sv
tb/sv/testbench.sv
